// ===== sv/olst_pkg.sv =====
// Package for the ordered list store: sizes, payload structs, codes and
// the control group that the top level drives into every list cell.
// No dependencies.
`timescale 1ns / 1ps

package olst_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0]        count_t;

    // Most negative value: sign bit alone
    localparam value_t VALUE_MIN = value_t'({1'b1, {(VALUE_BITS-1){1'b0}}});

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        COND_EQ = 2'd0,
        COND_LT = 2'd1,
        COND_GT = 2'd2
    } cond_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        op_t    op;
        value_t value;
        cond_t  cond;
    } in_t;

    typedef struct packed {
        status_t status;
        count_t  count;
        logic    is_empty;
        value_t  largest_value;
    } out_t;

    // Control broadcast to every cell in the chain
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        cond_t  cond;
        value_t ref_value;
    } olst_ctl_t;

endpackage

// ===== sv/olst_cell.sv =====
// One list cell: holds one entry, matches it against the reference,
// shifts toward either neighbor, and forwards a running maximum.
// Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_cell (
    input  logic               aclk,
    input  olst_pkg::olst_ctl_t ctl,
    input  logic               occupied,
    input  olst_pkg::value_t   left_value,
    input  olst_pkg::value_t   right_value,
    input  logic               hit_in,
    output logic               hit_out,
    output olst_pkg::value_t   value_out,
    input  olst_pkg::value_t   left_max,
    output olst_pkg::value_t   max_out
);
    import olst_pkg::*;

    value_t value_reg;
    value_t value_next;
    value_t max_reg;
    value_t max_next;
    logic   match;

    // Compare the held entry with the reference value
    always_comb begin
        unique case (ctl.cond)
            COND_EQ: match = occupied && (value_reg == ctl.ref_value);
            COND_LT: match = occupied && (value_reg <  ctl.ref_value);
            COND_GT: match = occupied && (value_reg >  ctl.ref_value);
            default: match = 1'b0;
        endcase
    end

    // Hit seen at this cell or any cell nearer the front
    assign hit_out = hit_in | match;

    // Shift back on insert, close the gap at and behind the hit on remove
    always_comb begin
        priority if (ctl.ins_en) begin
            value_next = left_value;
        end else if (ctl.rem_en && hit_out) begin
            value_next = right_value;
        end else begin
            value_next = value_reg;
        end
    end

    // Running maximum, one cell further each cycle
    assign max_next = (occupied && (value_reg > left_max)) ? value_reg : left_max;

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        max_reg   <= max_next;
    end

    assign value_out = value_reg;
    assign max_out   = max_reg;

endmodule

// ===== sv/ordered_list_store_core.sv =====
// Top level of the ordered list store: handshakes, entry count, result
// register and the chain of olst_cell instances.
// Depends on olst_pkg and olst_cell.
//
//   Port group   Dir  Handshake           Payload
//   s_*          in   s_valid / s_ready   s_data (olst_pkg::in_t)
//   m_*          out  m_valid / m_ready   m_data (olst_pkg::out_t)
//
// When a transaction is accepted on the s_ side, the match across all cells
// and the shift of the entries take effect at that accepting edge.
// The largest value then ripples through the cell chain, one cell per cycle,
// while the sequencer counts scan_reg down from CAPACITY in ST_SCAN; at zero
// it posts the result and returns to ST_IDLE to accept the next transaction.
// s_ready is high while no transaction is in flight; the result register lets
// a new transaction in while the last result still waits for m_ready.
// A stalled result holds the next finished transaction in its scan state.
// Reset (aresetn low at a clock edge) empties the list and drops any result.
`timescale 1ns / 1ps

module ordered_list_store_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  olst_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output olst_pkg::out_t  m_data
);
    import olst_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t    state_reg;
    count_t    count_reg;
    count_t    count_next;
    count_t    scan_reg;
    status_t   status_reg;
    status_t   status_next;
    logic      m_valid_reg;
    out_t      m_data_reg;
    logic      s_accept;
    logic      full;
    logic      hit_any;
    logic      post_result;
    olst_ctl_t ctl;

    logic   [CAPACITY-1:0] occupied;
    logic   [CAPACITY:0]   hit_chain;
    value_t                cell_value [CAPACITY];
    value_t                max_chain  [CAPACITY+1];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign full     = (count_reg == count_t'(CAPACITY));
    assign hit_any  = hit_chain[CAPACITY];

    // Post a result when the scan is done and the output register is free
    assign post_result = (state_reg == ST_SCAN) && (scan_reg == '0) &&
                         (!m_valid_reg || m_ready);

    // Drive the cells only at the accepting edge
    always_comb begin
        ctl.ins_en    = s_accept && (s_data.op == OP_INSERT) && !full;
        ctl.rem_en    = s_accept && (s_data.op == OP_REMOVE);
        ctl.cond      = s_data.cond;
        ctl.ref_value = s_data.value;
    end

    // Work out status and new count of the transaction being accepted
    always_comb begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        unique case (s_data.op)
            OP_INSERT: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + count_t'(1);
                end
            end
            OP_REMOVE: begin
                if (hit_any) begin
                    count_next = count_reg - count_t'(1);
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default: begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    // Cell chain
    assign hit_chain[0] = 1'b0;
    assign max_chain[0] = VALUE_MIN;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        value_t left_v;
        value_t right_v;

        assign occupied[i] = (count_t'(i) < count_reg);

        if (i == 0) begin : g_front
            assign left_v = s_data.value;
        end else begin : g_mid
            assign left_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_back
            assign right_v = VALUE_MIN;
        end else begin : g_inner
            assign right_v = cell_value[i+1];
        end

        olst_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .left_value  (left_v),
            .right_value (right_v),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i+1]),
            .value_out   (cell_value[i]),
            .left_max    (max_chain[i]),
            .max_out     (max_chain[i+1])
        );
    end

    // Sequencer: accept, wait for the maximum to reach the back, post result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            status_reg  <= STATUS_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop a taken result unless a new one replaces it this cycle
            if (m_valid_reg && m_ready && !post_result) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        count_reg  <= count_next;
                        status_reg <= status_next;
                        scan_reg   <= count_t'(CAPACITY);
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_reg != '0) begin
                        scan_reg <= scan_reg - count_t'(1);
                    end else if (post_result) begin
                        m_valid_reg              <= 1'b1;
                        m_data_reg.status        <= status_reg;
                        m_data_reg.count         <= count_reg;
                        m_data_reg.is_empty      <= (count_reg == '0);
                        m_data_reg.largest_value <= max_chain[CAPACITY];
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.status != STATUS_FULL) ||
                           (m_data.count == count_t'(CAPACITY)))
        else $error("full status with free cells");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_SCAN) && (scan_reg == count_t'(CAPACITY)))
        else $error("accepted transaction did not start a scan");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(count_reg))
        else $error("entry count changed without a transaction");

endmodule
